>>> rtl/lnpf_pkg.sv
// Shared types and constants of the lidar nearest-point finder.
// Used by the channel interfaces, the controller, the datapath and the sine ROM.
`timescale 1ns / 1ps
package lnpf_pkg;

   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam int RANGE_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int COORD_W    = 14;
   localparam int MAG_W      = COORD_W - 1;
   localparam int TURN_W     = 19;
   localparam int DIST_W     = 27;
   localparam int Q15_W      = 16;
   localparam int PROD_W     = RANGE_W + Q15_W;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 8;

   // Gate margin added to the range floor.
   localparam logic [RANGE_W:0] RANGE_MARGIN_MM = 17'd80;

   // Coordinates are (r * trig) / 327680 = ((r * trig) >> 16) / 5.
   localparam int COORD_SHIFT = 16;
   localparam logic [RANGE_W-1:0] RECIP_FIVE = 16'd52429;
   localparam int RECIP_SHIFT = 18;

   localparam logic [DIST_W-1:0] DIST_ALL_ONES = {DIST_W{1'b1}};

   // Sine table generation, Q30 Taylor series rounded to Q15.
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] Q15_ONE     = 64'd32768;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_RANGE_FLOOR   = 8'd0;
   localparam csr_index_type CSR_RANGE_CEILING = 8'd1;
   localparam csr_index_type CSR_START_ANGLE   = 8'd2;
   localparam csr_index_type CSR_STEP_ANGLE    = 8'd3;

   typedef struct packed {
      logic             neg;
      logic [Q15_W-1:0] mag;
   } trig_type;

   typedef struct packed {
      logic accept;
      logic rom_rd;
      logic mul;
      logic div;
      logic sqr;
      logic upd;
   } dp_cmd_type;

   typedef struct packed {
      logic kept;
      logic last;
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> rtl/lnpf_req_if.sv
// Range sample channel: valid/ready handshake with one scan sample.
// Depends on lnpf_pkg for field widths.
`timescale 1ns / 1ps
interface lnpf_req_if import lnpf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [RANGE_W-1:0] range_mm;
   logic               last_sample;

   modport source (output valid, output range_mm, output last_sample, input ready);
   modport sink (input valid, input range_mm, input last_sample, output ready);
endinterface

>>> rtl/lnpf_rsp_if.sv
// Result channel: valid/ready handshake with the nearest point of a scan.
// Depends on lnpf_pkg for field widths.
`timescale 1ns / 1ps
interface lnpf_rsp_if import lnpf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] nearest_x_cm;
   logic signed [COORD_W-1:0] nearest_y_cm;
   logic                      point_found;
   logic signed [TURN_W-1:0]  turn_mrad;

   modport source (output valid, output nearest_x_cm, output nearest_y_cm,
                   output point_found, output turn_mrad, input ready);
   modport sink (input valid, input nearest_x_cm, input nearest_y_cm,
                 input point_found, input turn_mrad, output ready);
endinterface

>>> rtl/lnpf_csr_if.sv
// Register write channel: valid/ready handshake with index and data.
// Depends on lnpf_pkg for the index type and data width.
`timescale 1ns / 1ps
interface lnpf_csr_if import lnpf_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_index_type         index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/lnpf_sine_rom.sv
// Quarter-wave sine ROM with two registered read ports (sine and cosine).
// The table is built at elaboration; depends on lnpf_pkg.
`timescale 1ns / 1ps
module lnpf_sine_rom import lnpf_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [SINE_TABLE_BITS-1:0] sin_idx,
   input  logic [SINE_TABLE_BITS-1:0] cos_idx,
   output trig_type                   sin_val,
   output trig_type                   cos_val
);

   localparam int ADDR_W = SINE_TABLE_BITS - 1;
   localparam int DEPTH  = (1 << (SINE_TABLE_BITS - 2)) + 1;
   localparam logic [ADDR_W-1:0] QUARTER_ADDR = ADDR_W'(1) << (SINE_TABLE_BITS - 2);

   typedef logic [Q15_W-1:0] rom_type [DEPTH];

   // sin(f * (pi/2) / 16384) in Q15, rounded half up, clamped to 1.0.
   function automatic logic [Q15_W-1:0] quarter_sine(input logic [63:0] f);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] s;
      x  = (f * HALF_PI_Q30 + 64'd8192) >> 14;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      t  = ONE_Q30;
      for (int k = 0; k < 6; k++) begin
         p = (x2 * t) >> 30;
         case (k)
            0: p = p / 64'd156;
            1: p = p / 64'd110;
            2: p = p / 64'd72;
            3: p = p / 64'd42;
            4: p = p / 64'd20;
            default: p = p / 64'd6;
         endcase
         t = ONE_Q30 - p;
      end
      s = (x * t) >> 30;
      s = (s + (64'd1 << 14)) >> 15;
      if (s > Q15_ONE) begin
         s = Q15_ONE;
      end
      return s[Q15_W-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type tab;
      for (int j = 0; j < DEPTH; j++) begin
         tab[j] = quarter_sine(64'(j) << (16 - SINE_TABLE_BITS));
      end
      return tab;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Odd quadrants run the quarter table backwards.
   function automatic logic [ADDR_W-1:0] fold_addr(input logic [SINE_TABLE_BITS-1:0] idx);
      logic [ADDR_W-1:0] j;
      j = ADDR_W'(idx[SINE_TABLE_BITS-3:0]);
      return idx[SINE_TABLE_BITS-2] ? QUARTER_ADDR - j : j;
   endfunction

   trig_type sin_val_ff;
   trig_type cos_val_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_val_ff.mag <= SINE_ROM[fold_addr(sin_idx)];
         sin_val_ff.neg <= sin_idx[SINE_TABLE_BITS-1];
         cos_val_ff.mag <= SINE_ROM[fold_addr(cos_idx)];
         cos_val_ff.neg <= cos_idx[SINE_TABLE_BITS-1];
      end
   end

   assign sin_val = sin_val_ff;
   assign cos_val = cos_val_ff;

endmodule

>>> rtl/lnpf_ctrl.sv
// Sequencer of the nearest-point finder: steps one sample through the datapath.
// Depends on lnpf_pkg for the command and status structs.
`timescale 1ns / 1ps
module lnpf_ctrl import lnpf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROM,
      ST_MUL,
      ST_DIV,
      ST_SQR,
      ST_UPD
   } state_type;

   state_type state_ff;
   logic      ready_ff;
   logic      upd_go;

   // A last sample may only retire once the result register is free.
   assign upd_go = !(status.last && status.rsp_busy);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && ready_ff) begin
                  state_ff <= ST_ROM;
                  ready_ff <= 1'b0;
               end
            end
            ST_ROM: state_ff <= status.kept ? ST_MUL : ST_UPD;
            ST_MUL: state_ff <= ST_DIV;
            ST_DIV: state_ff <= ST_SQR;
            ST_SQR: state_ff <= ST_UPD;
            ST_UPD: begin
               if (upd_go) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.accept = (state_ff == ST_IDLE) && req_valid && ready_ff;
      cmd.rom_rd = (state_ff == ST_ROM);
      cmd.mul    = (state_ff == ST_MUL);
      cmd.div    = (state_ff == ST_DIV);
      cmd.sqr    = (state_ff == ST_SQR);
      cmd.upd    = (state_ff == ST_UPD) && upd_go;
   end

   assign req_ready = ready_ff;

endmodule

>>> rtl/lnpf_datapath.sv
// Datapath of the nearest-point finder: registers, angle accumulator, range gate,
// coordinate math, best-point tracking and the result register. Depends on lnpf_pkg.
`timescale 1ns / 1ps
module lnpf_datapath import lnpf_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic [RANGE_W-1:0]        req_range_mm,
   input  logic                      req_last_sample,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_index_type             csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_nearest_x_cm,
   output logic signed [COORD_W-1:0] rsp_nearest_y_cm,
   output logic                      rsp_point_found,
   output logic signed [TURN_W-1:0]  rsp_turn_mrad
);

   localparam int IDX_W = SINE_TABLE_BITS;
   localparam logic [IDX_W-1:0] QUARTER_STEP = IDX_W'(1) << (IDX_W - 2);

   // Configuration registers
   logic [RANGE_W-1:0] floor_ff;
   logic [RANGE_W-1:0] ceiling_ff;
   logic [ANGLE_W-1:0] start_ff;
   logic [ANGLE_W-1:0] step_ff;

   // Scan state and the sample being worked on
   logic [ANGLE_W-1:0] scan_angle_ff;
   logic               in_scan_ff;
   logic [RANGE_W-1:0] range_ff;
   logic               last_ff;
   logic               kept_ff;
   logic [IDX_W-1:0]   sin_idx_ff;
   logic [IDX_W-1:0]   cos_idx_ff;

   logic [ANGLE_W-1:0] base_angle;
   logic [IDX_W-1:0]   base_idx;
   logic               gate_pass;

   trig_type sin_val;
   trig_type cos_val;

   logic [PROD_W-1:0] prod_x_ff;
   logic [PROD_W-1:0] prod_y_ff;
   logic              neg_x_ff;
   logic              neg_y_ff;
   logic              neg_x2_ff;
   logic              neg_y2_ff;
   logic [PROD_W-1:0] recip_x;
   logic [PROD_W-1:0] recip_y;
   logic [MAG_W-1:0]  mag_x_ff;
   logic [MAG_W-1:0]  mag_y_ff;

   logic [2*MAG_W-1:0]        sq_x;
   logic [2*MAG_W-1:0]        sq_y;
   logic signed [COORD_W-1:0] x_in;
   logic signed [COORD_W-1:0] y_in;
   logic signed [COORD_W-1:0] x_ff;
   logic signed [COORD_W-1:0] y_ff;
   logic [DIST_W-1:0]         dist_ff;

   logic [DIST_W-1:0]         best_dist_ff;
   logic signed [COORD_W-1:0] best_x_ff;
   logic signed [COORD_W-1:0] best_y_ff;
   logic                      found_ff;

   logic                      better;
   logic [DIST_W-1:0]         best_dist_in;
   logic signed [COORD_W-1:0] best_x_in;
   logic signed [COORD_W-1:0] best_y_in;
   logic                      found_in;
   logic signed [TURN_W-1:0]  x_wide;
   logic signed [TURN_W-1:0]  turn_in;

   logic                      rsp_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff;
   logic signed [COORD_W-1:0] out_y_ff;
   logic                      out_found_ff;
   logic signed [TURN_W-1:0]  out_turn_ff;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= '0;
         ceiling_ff <= '1;
         start_ff   <= '0;
         step_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_FLOOR:   floor_ff   <= csr_data;
            CSR_RANGE_CEILING: ceiling_ff <= csr_data;
            CSR_START_ANGLE:   start_ff   <= csr_data;
            CSR_STEP_ANGLE:    step_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Accept: angle accumulator, range gate and table indexes
   assign base_angle = in_scan_ff ? scan_angle_ff : start_ff;
   assign base_idx   = base_angle[ANGLE_W-1 -: IDX_W];
   assign gate_pass  = ({1'b0, req_range_mm} > ({1'b0, floor_ff} + RANGE_MARGIN_MM))
                       && (req_range_mm < ceiling_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_angle_ff <= '0;
         in_scan_ff    <= 1'b0;
         kept_ff       <= 1'b0;
         last_ff       <= 1'b0;
      end else if (cmd.accept) begin
         scan_angle_ff <= base_angle + step_ff;
         in_scan_ff    <= 1'b1;
         kept_ff       <= gate_pass;
         last_ff       <= req_last_sample;
      end else if (cmd.upd && last_ff) begin
         in_scan_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         range_ff   <= req_range_mm;
         sin_idx_ff <= base_idx;
         cos_idx_ff <= base_idx + QUARTER_STEP;
      end
   end

   lnpf_sine_rom #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .rd_en  (cmd.rom_rd),
      .sin_idx(sin_idx_ff),
      .cos_idx(cos_idx_ff),
      .sin_val(sin_val),
      .cos_val(cos_val)
   );

   // Range times trig magnitude; y carries the negated cosine sign.
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         prod_x_ff <= PROD_W'(range_ff) * PROD_W'(sin_val.mag);
         prod_y_ff <= PROD_W'(range_ff) * PROD_W'(cos_val.mag);
         neg_x_ff  <= sin_val.neg;
         neg_y_ff  <= !cos_val.neg;
      end
   end

   // Divide the magnitude by 327680: shift by 16, then reciprocal of five.
   assign recip_x = PROD_W'(prod_x_ff[PROD_W-1:COORD_SHIFT]) * PROD_W'(RECIP_FIVE);
   assign recip_y = PROD_W'(prod_y_ff[PROD_W-1:COORD_SHIFT]) * PROD_W'(RECIP_FIVE);

   always_ff @(posedge clock) begin
      if (cmd.div) begin
         mag_x_ff  <= recip_x[RECIP_SHIFT +: MAG_W];
         mag_y_ff  <= recip_y[RECIP_SHIFT +: MAG_W];
         neg_x2_ff <= neg_x_ff;
         neg_y2_ff <= neg_y_ff;
      end
   end

   // Signed coordinates and squared distance
   assign sq_x = mag_x_ff * mag_x_ff;
   assign sq_y = mag_y_ff * mag_y_ff;
   assign x_in = neg_x2_ff ? -$signed({1'b0, mag_x_ff}) : $signed({1'b0, mag_x_ff});
   assign y_in = neg_y2_ff ? -$signed({1'b0, mag_y_ff}) : $signed({1'b0, mag_y_ff});

   always_ff @(posedge clock) begin
      if (cmd.sqr) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         dist_ff <= DIST_W'(sq_x) + DIST_W'(sq_y);
      end
   end

   // Best-point update; strict less-than keeps the earlier point on a tie.
   assign better       = kept_ff && (dist_ff < best_dist_ff);
   assign best_dist_in = better ? dist_ff : best_dist_ff;
   assign best_x_in    = better ? x_ff : best_x_ff;
   assign best_y_in    = better ? y_ff : best_y_ff;
   assign found_in     = found_ff || kept_ff;
   assign x_wide       = TURN_W'(best_x_in);
   assign turn_in      = -((x_wide <<< 4) + (x_wide <<< 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_ff <= DIST_ALL_ONES;
         best_x_ff    <= '0;
         best_y_ff    <= '0;
         found_ff     <= 1'b0;
      end else if (cmd.upd) begin
         if (last_ff) begin
            best_dist_ff <= DIST_ALL_ONES;
            best_x_ff    <= '0;
            best_y_ff    <= '0;
            found_ff     <= 1'b0;
         end else begin
            best_dist_ff <= best_dist_in;
            best_x_ff    <= best_x_in;
            best_y_ff    <= best_y_in;
            found_ff     <= found_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.upd && last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.upd && last_ff) begin
         out_x_ff     <= best_x_in;
         out_y_ff     <= best_y_in;
         out_found_ff <= found_in;
         out_turn_ff  <= turn_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_nearest_x_cm = out_x_ff;
   assign rsp_nearest_y_cm = out_y_ff;
   assign rsp_point_found  = out_found_ff;
   assign rsp_turn_mrad    = out_turn_ff;

   assign status.kept     = kept_ff;
   assign status.last     = last_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

>>> rtl/lidar_nearest_point_finder.sv
// Top level of the lidar nearest-point finder: sequencer plus datapath.
// Depends on lnpf_pkg, the three channel interfaces, lnpf_ctrl and lnpf_datapath.
//
//   Channel   Direction   Carries
//   req_ch    in          range_mm, last_sample (one range sample per transfer)
//   rsp_ch    out         nearest_x_cm, nearest_y_cm, point_found, turn_mrad
//   csr_ch    in          index, data (register write per transfer)
//
// A sample that fails the range gate passes the table read and the compare step before
// the next transfer is possible; a kept sample passes every step in turn (table read,
// range multiply, reciprocal multiply, squaring, compare). Each of those steps is one
// register stage of the datapath, and only one sample is in flight at a time.
// Reset is synchronous; it clears the registers to their defaults, ends any scan
// and drops a pending result. No clearing pass is needed after reset.
// A last sample waits in its compare step while a previous result is still
// untaken on rsp_ch; otherwise a waiting result never holds up req_ch.
`timescale 1ns / 1ps
module lidar_nearest_point_finder import lnpf_pkg::*; #(
   parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   lnpf_req_if.sink    req_ch,
   lnpf_rsp_if.source  rsp_ch,
   lnpf_csr_if.sink    csr_ch
);

   // Commands go from the sequencer to the datapath, status comes back.
   dp_cmd_type    cmd;
   dp_status_type status;

   // The sequencer owns req_ch.ready: it is high only while no sample is in flight.
   lnpf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // The datapath holds the registers, the scan state, the sine table and the
   // result register that drives rsp_ch.
   lnpf_datapath #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_range_mm    (req_ch.range_mm),
      .req_last_sample (req_ch.last_sample),
      .csr_valid       (csr_ch.valid),
      .csr_ready       (csr_ch.ready),
      .csr_index       (csr_ch.index),
      .csr_data        (csr_ch.data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_nearest_x_cm(rsp_ch.nearest_x_cm),
      .rsp_nearest_y_cm(rsp_ch.nearest_y_cm),
      .rsp_point_found (rsp_ch.point_found),
      .rsp_turn_mrad   (rsp_ch.turn_mrad)
   );

endmodule

>>> tb/testbench.sv
// Self-checking testbench for lidar_nearest_point_finder: range samples in, nearest point out.
// Depends on lnpf_pkg, the lnpf_req_if/lnpf_rsp_if/lnpf_csr_if channel interfaces and the RTL.
// A scoreboard class predicts each scan result and checks every result transfer in order.
`timescale 1ns / 1ps
module testbench;
   import lnpf_pkg::*;

   // The sine table resolution of the block under test and of the prediction.
   localparam int SINE_BITS    = 10;
   localparam int SINE_ENTRIES = 1 << SINE_BITS;

   localparam longint COORD_DIVISOR  = 327680;
   localparam longint TURN_GAIN      = 20;
   localparam int unsigned GATE_MARGIN = 80;
   localparam longint unsigned Q30_ONE     = 64'd1 << 30;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

   // Register indexes past the four real registers; writes to them must be ignored.
   localparam csr_index_type CSR_UNUSED_LOW = 8'd4;
   localparam csr_index_type CSR_UNUSED_TOP = 8'hFF;

   localparam int ITEM_TARGET   = 1950;
   localparam int MAX_GAP       = 17;
   // Settling wait that outlasts a kept sample's way through the datapath.
   localparam int SETTLE_CYCLES = 12;
   localparam int REPORT_LIMIT  = 10;
   // Timeout, many times the slowest legal run.
   localparam longint TIMEOUT_NS = 64'd10_000_000;

   typedef struct {
      logic signed [COORD_W-1:0] x_cm;
      logic signed [COORD_W-1:0] y_cm;
      logic                      found;
      logic signed [TURN_W-1:0]  turn_mrad;
   } nearest_point_type;

   // Scoreboard: keeps its own copy of the registers and of the scan state, works out
   // the nearest point of every scan when its last sample transfers, and checks the
   // result transfers against those predictions in order.
   class nearest_point_scoreboard;
      logic [RANGE_W-1:0] floor_mm;
      logic [RANGE_W-1:0] ceiling_mm;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] step_angle;

      logic [ANGLE_W-1:0] scan_angle;
      longint             best_dist;
      longint             best_x;
      longint             best_y;
      bit                 found;
      bit                 in_scan;

      int                 sine_q15[SINE_ENTRIES];
      nearest_point_type  expected_points[$];

      int scans_closed;
      int kept_samples;
      int register_writes;
      int results_checked;
      int failures;

      function new();
         for (int i = 0; i < SINE_ENTRIES; i++) begin
            sine_q15[i] = table_sine(i);
         end
         floor_mm    = '0;
         ceiling_mm  = '1;
         start_angle = '0;
         step_angle  = '0;
         scan_angle  = '0;
         in_scan     = 1'b0;
         clear_best();
      endfunction

      // Sine over the first quadrant, f = 0..16384, by a Q30 Taylor series rounded to Q15.
      function int quarter_sine(int unsigned f);
         longint unsigned x, x2, t, s, div;
         x  = (64'(f) * Q30_HALF_PI + 64'd8192) >> 14;
         x2 = (x * x + (64'd1 << 29)) >> 30;
         t  = Q30_ONE;
         for (int k = 0; k < 6; k++) begin
            div = 64'((13 - 2 * k) * (12 - 2 * k));
            t = Q30_ONE - ((x2 * t) >> 30) / div;
         end
         s = (x * t) >> 30;
         s = (s + (64'd1 << 14)) >> 15;
         if (s > 64'd32768) s = 64'd32768;
         return int'(s);
      endfunction

      function int table_sine(int unsigned i);
         int unsigned a, q, f;
         int m;
         a = (i % SINE_ENTRIES) << (16 - SINE_BITS);
         q = (a >> 14) & 3;
         f = a & 16'h3FFF;
         if (q[0]) f = 16384 - f;
         m = quarter_sine(f);
         return (q >= 2) ? -m : m;
      endfunction

      function void clear_best();
         best_dist = 64'h7FF_FFFF;
         best_x    = 0;
         best_y    = 0;
         found     = 1'b0;
      endfunction

      function void record_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
         register_writes++;
         case (idx)
            CSR_RANGE_FLOOR:   floor_mm    = value;
            CSR_RANGE_CEILING: ceiling_mm  = value;
            CSR_START_ANGLE:   start_angle = value;
            CSR_STEP_ANGLE:    step_angle  = value;
            default: ;
         endcase
      endfunction

      function void track_sample(logic [RANGE_W-1:0] r_mm, logic last_sample);
         int unsigned r, gate_low, idx;
         longint s, c, x, y, d;
         nearest_point_type pt;
         if (!in_scan) begin
            scan_angle = start_angle;
            in_scan    = 1'b1;
         end
         r        = r_mm;
         gate_low = floor_mm;
         gate_low = gate_low + GATE_MARGIN;
         if (r > gate_low && r < ceiling_mm) begin
            idx = scan_angle >> (16 - SINE_BITS);
            s = sine_q15[idx];
            c = sine_q15[(idx + SINE_ENTRIES / 4) % SINE_ENTRIES];
            x = (longint'(r) * s) / COORD_DIVISOR;
            y = -((longint'(r) * c) / COORD_DIVISOR);
            d = x * x + y * y;
            // Strict compare: on equal distance the earlier point stays.
            if (d < best_dist) begin
               best_dist = d;
               best_x    = x;
               best_y    = y;
            end
            found = 1'b1;
            kept_samples++;
         end
         scan_angle = scan_angle + step_angle;
         if (last_sample) begin
            pt.x_cm      = best_x;
            pt.y_cm      = best_y;
            pt.found     = found;
            pt.turn_mrad = found ? -TURN_GAIN * best_x : 0;
            expected_points.insert(expected_points.size(), pt);
            scans_closed++;
            in_scan = 1'b0;
            clear_best();
         end
      endfunction

      function void check_point(nearest_point_type got);
         nearest_point_type want;
         if (expected_points.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: result with no scan closed: x=%0d y=%0d found=%0b turn=%0d",
                        $time, got.x_cm, got.y_cm, got.found, got.turn_mrad);
            return;
         end
         want = expected_points.pop_front();
         results_checked++;
         if (got.x_cm !== want.x_cm || got.y_cm !== want.y_cm ||
             got.found !== want.found || got.turn_mrad !== want.turn_mrad) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display({"%0t: mismatch, expected x=%0d y=%0d found=%0b turn=%0d, ",
                         "got x=%0d y=%0d found=%0b turn=%0d"},
                        $time, want.x_cm, want.y_cm, want.found, want.turn_mrad,
                        got.x_cm, got.y_cm, got.found, got.turn_mrad);
         end
      endfunction

      function void check_drained();
         if (expected_points.size() != 0) begin
            failures += expected_points.size();
            $display("%0d expected results never arrived", expected_points.size());
         end
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;

   lnpf_req_if req_ch ();
   lnpf_rsp_if rsp_ch ();
   lnpf_csr_if csr_ch ();

   lidar_nearest_point_finder #(
      .SINE_TABLE_BITS(SINE_BITS)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   nearest_point_scoreboard sb = new();

   // When set, neither side inserts idle cycles, so the block runs at full rate.
   bit steady_flow = 1'b0;
   int samples_sent = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs a handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("testbench: done, errors");
      $finish;
   end

   // Idle cycles that one side waits before its next transfer.
   function automatic int draw_gap();
      if (steady_flow) return 0;
      return $urandom_range(MAX_GAP, 0);
   endfunction

   // Range for a random sample. Most land inside the current gate so that scans carry
   // real points; the rest are uniform noise or sit right on the gate edges.
   function automatic logic [RANGE_W-1:0] pick_range();
      int unsigned lo, hi, edge_lo;
      lo      = sb.floor_mm;
      lo      = lo + GATE_MARGIN + 1;
      hi      = sb.ceiling_mm;
      edge_lo = (lo - 1 > 65535) ? 65535 : lo - 1;
      case ($urandom_range(9, 0))
         0, 1: return $urandom_range(65535, 0);
         2: begin
            case ($urandom_range(5, 0))
               0: return edge_lo;
               1: return (lo > 65535) ? 65535 : lo;
               2: return (hi == 0) ? 0 : hi - 1;
               3: return hi;
               4: return 0;
               default: return 16'hFFFF;
            endcase
         end
         default: begin
            if (hi >= 1 && lo <= hi - 1) return $urandom_range(hi - 1, lo);
            return $urandom_range(65535, 0);
         end
      endcase
   endfunction

   // Sends one sample; called at a falling edge and returns at a falling edge with
   // valid still high, so back-to-back samples need no dead cycle.
   task automatic send_sample(input logic [RANGE_W-1:0] r_mm, input logic last_sample);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       = 1'b1;
      req_ch.range_mm    = r_mm;
      req_ch.last_sample = last_sample;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.track_sample(r_mm, last_sample);
      samples_sent++;
      @(negedge clock);
   endtask

   // Holds off the sample stream until every predicted result has been taken, then
   // lets any sample still in the datapath finish.
   task automatic wait_idle();
      req_ch.valid = 1'b0;
      while (sb.expected_points.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data  = value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      sb.record_register(idx, value);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic write_all(input logic [15:0] floor_v, input logic [15:0] ceil_v,
                            input logic [15:0] start_v, input logic [15:0] step_v);
      write_register(CSR_RANGE_FLOOR, floor_v);
      write_register(CSR_RANGE_CEILING, ceil_v);
      write_register(CSR_START_ANGLE, start_v);
      write_register(CSR_STEP_ANGLE, step_v);
   endtask

   // Result side: a random stall before each transfer, then ready until one arrives.
   initial begin : result_sink
      int stall;
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin : result_check
      nearest_point_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.x_cm      = rsp_ch.nearest_x_cm;
         got.y_cm      = rsp_ch.nearest_y_cm;
         got.found     = rsp_ch.point_found;
         got.turn_mrad = rsp_ch.turn_mrad;
         sb.check_point(got);
      end
   end

   initial begin : stimulus
      int len, phase_end;
      req_ch.valid       = 1'b0;
      req_ch.range_mm    = '0;
      req_ch.last_sample = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.index       = CSR_RANGE_FLOOR;
      csr_ch.data        = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: gate is (80, 65535), angle fixed at zero. Zero and exactly
      // the margin are rejected, one above it is kept, and the ceiling itself is out.
      send_sample(16'd0, 1'b0);
      send_sample(16'd80, 1'b0);
      send_sample(16'd81, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'hFFFE, 1'b1);
      // A scan with no kept sample must report nothing found and a zero turn.
      send_sample(16'd0, 1'b1);

      // Half-turn steps give two points at the same distance on opposite sides; the
      // first one must stay. Writes to unused indexes must change nothing.
      wait_idle();
      write_all(16'd100, 16'd1000, 16'h0000, 16'h8000);
      write_register(CSR_UNUSED_LOW, 16'h1234);
      write_register(CSR_UNUSED_TOP, 16'hFFFF);
      send_sample(16'd180, 1'b0);
      send_sample(16'd500, 1'b0);
      send_sample(16'd500, 1'b0);
      send_sample(16'd1000, 1'b0);
      send_sample(16'd999, 1'b1);

      // Registers changed in the middle of a scan: the new step applies from the next
      // sample, while the new start angle waits for the following scan.
      wait_idle();
      send_sample(16'd300, 1'b0);
      wait_idle();
      write_register(CSR_STEP_ANGLE, 16'h4000);
      write_register(CSR_START_ANGLE, 16'hC000);
      send_sample(16'd300, 1'b0);
      send_sample(16'd300, 1'b1);
      send_sample(16'd300, 1'b1);

      // Register extremes: a closed gate from either side, then the widest gate with
      // the start and step angles at their top value.
      wait_idle();
      write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'd0, 1'b1);
      wait_idle();
      write_all(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 1'b1);
      wait_idle();
      write_register(CSR_RANGE_CEILING, 16'hFFFF);
      send_sample(16'hFFFE, 1'b0);
      send_sample(16'd40000, 1'b0);
      send_sample(16'd12345, 1'b1);

      // Random phases: new register settings once the block has drained, then whole
      // scans of random length and content. Some phases run without any idle cycles.
      while (samples_sent < ITEM_TARGET) begin
         wait_idle();
         steady_flow = ($urandom_range(3, 0) == 0);
         case ($urandom_range(3, 0))
            0: write_register(CSR_RANGE_FLOOR, 16'd0);
            1: write_register(CSR_RANGE_FLOOR, $urandom_range(65535, 0));
            default: write_register(CSR_RANGE_FLOOR, $urandom_range(3000, 0));
         endcase
         case ($urandom_range(3, 0))
            0: write_register(CSR_RANGE_CEILING, 16'hFFFF);
            1: write_register(CSR_RANGE_CEILING, $urandom_range(65535, 0));
            default: write_register(CSR_RANGE_CEILING, $urandom_range(65535, 20000));
         endcase
         write_register(CSR_START_ANGLE, $urandom_range(65535, 0));
         case ($urandom_range(4, 0))
            0: write_register(CSR_STEP_ANGLE, 16'd0);
            1: write_register(CSR_STEP_ANGLE, $urandom_range(65535, 0));
            default: write_register(CSR_STEP_ANGLE, $urandom_range(2048, 1));
         endcase
         if ($urandom_range(4, 0) == 0)
            write_register(csr_index_type'($urandom_range(CSR_UNUSED_TOP, CSR_UNUSED_LOW)),
                           $urandom_range(65535, 0));
         phase_end = samples_sent + $urandom_range(200, 60);
         while (samples_sent < phase_end && samples_sent < ITEM_TARGET) begin
            len = ($urandom_range(7, 0) == 0) ? $urandom_range(3, 1) : $urandom_range(30, 1);
            for (int k = 0; k < len; k++) begin
               send_sample(pick_range(), k == len - 1);
            end
         end
      end

      wait_idle();
      sb.check_drained();
      $display("Sent %0d samples in %0d scans (%0d passed the range gate), %0d register writes.",
               samples_sent, sb.scans_closed, sb.kept_samples, sb.register_writes);
      $display("Checked %0d nearest-point results, %0d failures.",
               sb.results_checked, sb.failures);
      if (sb.failures == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
